### rtl/sensor_count_to_temperature_macros.svh
// ----------------------------------------------------------------------------
// Sensor count to temperature: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SENSOR_COUNT_TO_TEMPERATURE_MACROS_SVH
`define SENSOR_COUNT_TO_TEMPERATURE_MACROS_SVH

// property holds at every edge outside reset
`define SCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sct assertion failed");

// antecedent implies consequent in the same cycle
`define SCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    `SCT_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

### rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// Sensor count to temperature: package
// Widths, constants, register indexes and the divider pipeline word.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int SAMPLE_BITS = 10;

    localparam int FAULT_LIMIT = 800;
    localparam int FAULT_TEMP  = 999;
    localparam int BASE_COUNT  = 310;
    localparam int SCALE_MUL   = 100;
    localparam int SPAN_BASE   = 400;
    localparam int MAX_TEMP    = 226;

    localparam int CFG_BITS       = 8;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN_TRIM   = 1'd1;

    localparam int TEMP_BITS = 10;
    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int VAL_BITS  = 10;
    localparam int PROD_BITS = 16;
    localparam int DIV_BITS  = 10;
    localparam int QUO_BITS  = 8;
    localparam int DS_BITS   = DIV_BITS + QUO_BITS - 1;

    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;

    typedef struct packed {
        logic                 valid;
        logic                 fault;
        logic [PROD_BITS-1:0] rem;
        logic [DS_BITS-1:0]   ds;
        logic [QUO_BITS-1:0]  quo;
    } div_word_t;

endpackage

### rtl/sct_front.sv
// ----------------------------------------------------------------------------
// Sensor count to temperature: front end
// Fault check, offset and clamp, then scale by 100 and load the divider word.
// ----------------------------------------------------------------------------
module sct_front
    import sct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] sample_count,
    input  logic signed [CFG_BITS-1:0] zero_offset,
    input  logic signed [CFG_BITS-1:0] span_trim,
    output div_word_t              word_out
);

    logic                s1_valid_reg;
    logic                s1_fault_reg;
    logic [VAL_BITS-1:0] s1_val_reg;
    logic [DIV_BITS-1:0] s1_div_reg;

    logic                s1_fault_next;
    logic [VAL_BITS-1:0] s1_val_next;
    logic [DIV_BITS-1:0] s1_div_next;
    logic signed [SUM_BITS-1:0] sum;

    logic                 s2_valid_reg;
    logic                 s2_fault_reg;
    logic [PROD_BITS-1:0] s2_prod_reg;
    logic [DIV_BITS-1:0]  s2_div_reg;
    logic [PROD_BITS-1:0] s2_prod_next;

    always_comb
    begin
        s1_fault_next = (32'(sample_count) > FAULT_LIMIT);
        sum = SUM_BITS'($signed({2'b00, sample_count})) + SUM_BITS'(zero_offset)
            - SUM_BITS'(BASE_COUNT);
        if (sum[SUM_BITS-1])
        begin
            s1_val_next = '0;
        end
        else
        begin
            s1_val_next = VAL_BITS'(sum);
        end
        s1_div_next = DIV_BITS'(SPAN_BASE - 32'(span_trim));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fault_reg <= s1_fault_next;
        s1_val_reg   <= s1_val_next;
        s1_div_reg   <= s1_div_next;
    end

    assign s2_prod_next = PROD_BITS'(s1_val_reg) * PROD_BITS'(SCALE_MUL);

    always_ff @(posedge clk)
    begin
        s2_fault_reg <= s1_fault_reg;
        s2_prod_reg  <= s2_prod_next;
        s2_div_reg   <= s1_div_reg;
    end

    always_comb
    begin
        word_out.valid = s2_valid_reg;
        word_out.fault = s2_fault_reg;
        word_out.rem   = s2_prod_reg;
        word_out.ds    = {s2_div_reg, {(QUO_BITS-1){1'b0}}};
        word_out.quo   = '0;
    end

endmodule

### rtl/sct_div_stage.sv
// ----------------------------------------------------------------------------
// Sensor count to temperature: divider stage
// Two restoring division steps, then a register.
// ----------------------------------------------------------------------------
module sct_div_stage
    import sct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_word_t word_in,
    output div_word_t word_out
);

    logic                 valid_reg;
    div_word_t            word_reg;
    div_word_t            word_next;
    logic [PROD_BITS-1:0] rem;
    logic [DS_BITS-1:0]   ds;
    logic [QUO_BITS-1:0]  quo;

    always_comb
    begin
        rem = word_in.rem;
        ds  = word_in.ds;
        quo = word_in.quo;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (DS_BITS'(rem) >= ds)
            begin
                rem = rem - PROD_BITS'(ds);
                quo = {quo[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                quo = {quo[QUO_BITS-2:0], 1'b0};
            end
            ds = ds >> 1;
        end
        word_next       = word_in;
        word_next.rem   = rem;
        word_next.ds    = ds;
        word_next.quo   = quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= word_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_comb
    begin
        word_out       = word_reg;
        word_out.valid = valid_reg;
    end

endmodule

### rtl/sensor_count_to_temperature.sv
// ----------------------------------------------------------------------------
// Sensor count to temperature
// Converter count to temperature with open-sensor fault flag.
// ----------------------------------------------------------------------------
//  channel   handshake           word
//  ------    ---------           ----
//  input     start && !busy      sample_count
//  result    done (one cycle)    temperature, sensor_fault
//  config    cfg_we              cfg_index, cfg_data
//
//  One word accepted per cycle; busy stays low.
//  Result passes through two front stages, four divider stages of
//  two quotient bits each, and one output register.
//  Reset clears pipeline valid bits and both calibration registers.
//  No backpressure: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`include "sensor_count_to_temperature_macros.svh"

module sensor_count_to_temperature
    import sct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [SAMPLE_BITS-1:0]    sample_count,
    output logic                      done,
    output logic [TEMP_BITS-1:0]      temperature,
    output logic                      sensor_fault,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int LATENCY = 7;

    logic signed [CFG_BITS-1:0] zero_offset_reg;
    logic signed [CFG_BITS-1:0] span_trim_reg;

    logic                 done_reg;
    logic [TEMP_BITS-1:0] temperature_reg;
    logic                 sensor_fault_reg;
    logic [TEMP_BITS-1:0] temperature_next;

    logic      accept;
    div_word_t stage_word [DIV_STAGES+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= '0;
            span_trim_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_OFFSET: zero_offset_reg <= cfg_data;
                REG_SPAN_TRIM:   span_trim_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    sct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .sample_count (sample_count),
        .zero_offset  (zero_offset_reg),
        .span_trim    (span_trim_reg),
        .word_out     (stage_word[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        sct_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (stage_word[g]),
            .word_out (stage_word[g+1])
        );
    end

    always_comb
    begin
        if (stage_word[DIV_STAGES].fault)
        begin
            temperature_next = TEMP_BITS'(FAULT_TEMP);
        end
        else
        begin
            temperature_next = TEMP_BITS'(stage_word[DIV_STAGES].quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_word[DIV_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        temperature_reg  <= temperature_next;
        sensor_fault_reg <= stage_word[DIV_STAGES].fault;
    end

    assign done         = done_reg;
    assign temperature  = temperature_reg;
    assign sensor_fault = sensor_fault_reg;

    `SCT_ASSERT_IMPL(a_fault_temp, clk, rst_n, done && sensor_fault, temperature == FAULT_TEMP)
    `SCT_ASSERT_IMPL(a_temp_range, clk, rst_n, done && !sensor_fault, temperature <= MAX_TEMP)
    `SCT_ASSERT(a_latency, clk, rst_n, accept |-> ##LATENCY done)
    `SCT_ASSERT(a_fault_path, clk, rst_n,
        (accept && (32'(sample_count) > FAULT_LIMIT)) |-> ##LATENCY (done && sensor_fault))

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench: sensor count to temperature
// Drives converter counts under several calibration settings and sender
// gap rates, predicts each temperature and fault flag, and compares every
// result word against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_top
    import sct_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 200;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [TEMP_BITS-1:0] temp;
        logic                 fault;
    } reading_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic                      busy;
    logic [SAMPLE_BITS-1:0]    sample_count = '0;
    logic                      done;
    logic [TEMP_BITS-1:0]      temperature;
    logic                      sensor_fault;
    logic                      cfg_we       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = REG_ZERO_OFFSET;
    logic [CFG_BITS-1:0]       cfg_data     = '0;

    logic [SAMPLE_BITS-1:0] pending_counts[$];
    reading_t               expected_readings[$];
    logic [CFG_BITS-1:0]    zero_offset_cfg = '0;
    logic [CFG_BITS-1:0]    span_trim_cfg   = '0;
    logic                   word_taken      = 1'b0;
    int                     idle_pct        = 0;
    int                     failures        = 0;
    int                     cycles          = 0;

    sensor_count_to_temperature dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_count (sample_count),
        .done         (done),
        .temperature  (temperature),
        .sensor_fault (sensor_fault),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic reading_t predict_reading(input logic [SAMPLE_BITS-1:0] cnt);
        reading_t r;
        int       offset;
        int       trim;
        int       value;
        offset = $signed(zero_offset_cfg);
        trim   = $signed(span_trim_cfg);
        if (int'(cnt) > FAULT_LIMIT)
        begin
            r.temp  = TEMP_BITS'(FAULT_TEMP);
            r.fault = 1'b1;
        end
        else
        begin
            value = int'(cnt) - BASE_COUNT + offset;
            if (value < 0)
                value = 0;
            r.temp  = TEMP_BITS'((value * SCALE_MUL) / (SPAN_BASE - trim));
            r.fault = 1'b0;
        end
        return r;
    endfunction

    // mostly in-range counts, some faults, some around the base and the limit
    function automatic logic [SAMPLE_BITS-1:0] random_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return SAMPLE_BITS'($urandom_range(FAULT_LIMIT, 0));
        else if (pick < 72)
            return SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1, FAULT_LIMIT + 1));
        else if (pick < 84)
            return SAMPLE_BITS'($urandom_range(BASE_COUNT + 140, BASE_COUNT - 140));
        else if (pick < 92)
            return SAMPLE_BITS'($urandom_range(FAULT_LIMIT + 3, FAULT_LIMIT - 3));
        else
            return SAMPLE_BITS'($urandom);
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (word_taken)
            pending_counts.delete(0);
        if (start && !word_taken)
        begin
            // word offered but not taken yet: hold it
        end
        else if (pending_counts.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            start        <= 1'b1;
            sample_count <= pending_counts[0];
        end
        else
        begin
            start        <= 1'b0;
            sample_count <= SAMPLE_BITS'($urandom);
        end
    end

    // monitor: accepts words, tracks calibration, checks results
    always @(posedge clk)
    begin
        reading_t want;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= start && !busy;
            if (start && !busy)
                expected_readings.push_back(predict_reading(sample_count));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ZERO_OFFSET: zero_offset_cfg = cfg_data;
                    REG_SPAN_TRIM:   span_trim_cfg   = cfg_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_readings.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result word: temperature %0d fault %0b",
                                 temperature, sensor_fault);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (temperature !== want.temp || sensor_fault !== want.fault)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("mismatch: temperature exp %0d got %0d, fault exp %0b got %0b",
                                     want.temp, temperature, want.fault, sensor_fault);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_counts.size() != 0 || expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_data  <= CFG_BITS'($urandom);
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] offsets[8];
        logic [CFG_BITS-1:0] trims[8];
        int                  gaps[8];
        offsets = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00};
        trims   = '{8'h80, 8'h7F, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00};
        gaps    = '{0, 80, 22, 0, 80, 22, 0, 22};
        for (int i = 5; i < 8; i++)
        begin
            offsets[i] = CFG_BITS'($urandom);
            trims[i]   = CFG_BITS'($urandom);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset calibration: limits, base, fault threshold, bit patterns
        @(posedge clk);
        idle_pct = 0;
        pending_counts = '{10'd0, 10'd1023, 10'd800, 10'd801, 10'd799, 10'd310,
                           10'd309, 10'd311, 10'd314, 10'd1, 10'd512, 10'h155,
                           10'h2AA, 10'd802, 10'd0, 10'd800};

        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            write_reg(REG_ZERO_OFFSET, offsets[p]);
            write_reg(REG_SPAN_TRIM, trims[p]);
            @(posedge clk);
            idle_pct = gaps[p];
            for (int n = 0; n < PHASE_WORDS; n++)
                pending_counts.push_back(random_count());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && expected_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sct_pkg.sv
rtl/sct_front.sv
rtl/sct_div_stage.sv
rtl/sensor_count_to_temperature.sv
tb/sv/tb_top.sv
